>>> hdl/hsvrgb_pkg.sv
// Shared types, constants and divider step functions of the HSV/RGB converter.
package hsvrgb_pkg;

  localparam int unsigned HueSector     = 3840;
  localparam int unsigned HueFull       = 6 * HueSector;
  localparam int unsigned ChanMax       = 255;
  localparam int unsigned FullScale     = ChanMax * HueSector;
  // FullScale split as 256 * CeilDivisor; the low factor is taken off by a shift
  localparam int unsigned CeilShift     = 8;
  localparam int unsigned CeilDivisor   = FullScale / (1 << CeilShift);
  localparam int unsigned DivBits       = 12;
  localparam int unsigned NumWidth      = 20;
  localparam int unsigned ProdWidth     = NumWidth + CeilShift;
  localparam int unsigned DivStages     = 3;
  localparam int unsigned StepsPerStage = DivBits / DivStages;
  localparam int unsigned NumLanes      = 2;

  // Lane roles: hue quotient or q ceiling, saturation or t ceiling
  localparam int unsigned LaneA = 0;
  localparam int unsigned LaneB = 1;

  typedef enum logic {
    FuncHsvToRgb = 1'b0,
    FuncRgbToHsv = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    SecRedYellow    = 3'd0,
    SecYellowGreen  = 3'd1,
    SecGreenCyan    = 3'd2,
    SecCyanBlue     = 3'd3,
    SecBlueMagenta  = 3'd4,
    SecMagentaRed   = 3'd5
  } sector_e;

  typedef enum logic [1:0] {
    SelRed   = 2'd0,
    SelGreen = 2'd1,
    SelBlue  = 2'd2
  } sel_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [14:0] in_hue;
    logic [7:0]  in_sat;
    logic [7:0]  in_val;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [14:0] out_hue;
    logic [7:0]  out_sat;
    logic [7:0]  out_val;
    logic        hue_undefined;
  } out_beat_t;

  typedef struct packed {
    logic [DivBits-1:0] rem;
    logic [DivBits-1:0] bits;
    logic [DivBits-1:0] quo;
    logic [DivBits-1:0] dvs;
  } div_lane_t;

  // Side data that rides along with the divider lanes
  typedef struct packed {
    func_e       func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  p;
    sector_e     sector;
    sel_e        sel;
    logic        neg;
    logic        black;
    logic        grey;
  } side_t;

  typedef struct packed {
    side_t                      side;
    div_lane_t [NumLanes-1:0]   lane;
  } mid_t;

  // Load a lane; caller guarantees num < dvs * 2**DivBits
  function automatic div_lane_t lane_init(logic [NumWidth-1:0] num, logic [DivBits-1:0] dvs);
    div_lane_t res;
    res.rem  = DivBits'(num[NumWidth-1:DivBits]);
    res.bits = num[DivBits-1:0];
    res.quo  = '0;
    res.dvs  = dvs;
    return res;
  endfunction

  // Restoring division, StepsPerStage quotient bits
  function automatic div_lane_t div_steps(div_lane_t lane);
    div_lane_t          res;
    logic [DivBits:0]   part;
    res = lane;
    for (int i = 0; i < StepsPerStage; i++) begin
      part     = {res.rem, res.bits[DivBits-1]};
      res.bits = {res.bits[DivBits-2:0], 1'b0};
      if (part >= {1'b0, res.dvs}) begin
        part    = part - {1'b0, res.dvs};
        res.quo = {res.quo[DivBits-2:0], 1'b1};
      end else begin
        res.quo = {res.quo[DivBits-2:0], 1'b0};
      end
      res.rem = part[DivBits-1:0];
    end
    return res;
  endfunction

endpackage

>>> hdl/hsv_rgb_color_converter_unit.sv
// Top level of the HSV/RGB color converter pipeline.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one color per beat.
// func selects the direction: HSV to RGB or RGB to HSV. Hue is in 1/64
// degree (0..23039), channels, saturation and value are 8-bit with 255
// standing for 1.0. A hue of 23040 or more is treated as 0.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per
// input beat, in order. In RGB to HSV mode the input channels come back in
// the RGB fields; in HSV to RGB mode the wrapped hue, saturation and value
// come back in the HSV fields. Black RGB to HSV input sets hue_undefined.
//
// Pipeline: six register stages, the depth coming mostly from the
// three-stage divider, four quotient bits per lane each. Throughput: one
// beat per cycle while the output is not stalled, since every stage is
// fully pipelined.
// Each stage holds its own valid bit, so bubbles collapse when the output
// stalls and a new beat is taken while a finished result is still waiting.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// A stalled receiver backs the pipe up stage by stage; in_ready_o drops
// only once every stage is full.
module hsv_rgb_color_converter_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hsvrgb_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsvrgb_pkg::out_beat_t out_data_o
);
  import hsvrgb_pkg::*;

  // prep -> divider
  logic pd_valid, pd_ready;
  mid_t pd_data;
  // divider -> output stage
  logic dp_valid, dp_ready;
  mid_t dp_data;

  // Stages 1-2: sector, extremes, products, p, lane setup
  hsvrgb_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (pd_valid),
    .ready_i (pd_ready),
    .data_o  (pd_data)
  );

  // Stages 3-5: hue/saturation quotients or the q and t ceilings
  hsvrgb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pd_valid),
    .ready_o (pd_ready),
    .data_i  (pd_data),
    .valid_o (dp_valid),
    .ready_i (dp_ready),
    .data_o  (dp_data)
  );

  // Stage 6: select channels, assemble hue, hold the result
  hsvrgb_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dp_valid),
    .ready_o (dp_ready),
    .data_i  (dp_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

>>> hdl/hsvrgb_prep.sv
// Front two pipeline stages: sector, extremes, products and divider lane setup.
module hsvrgb_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsvrgb_pkg::in_beat_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsvrgb_pkg::mid_t     data_o
);
  import hsvrgb_pkg::*;

  typedef struct packed {
    func_e       func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    sector_e     sector;
    logic [11:0] frac;
    logic [15:0] vs;
    logic [15:0] pnum;
    logic [7:0]  mx;
    logic [7:0]  delta;
    logic [7:0]  dmag;
    sel_e        sel;
    logic        neg;
  } s1_t;

  s1_t  s1_d, s1_q;
  mid_t s2_d, s2_q;
  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;

  logic [14:0] hue_w, base;
  logic [7:0]  mn, opa, opb, sat_c;
  logic        red_max, green_max;

  // Stage 1: wrap hue, find sector and fraction, extremes of the channels
  always_comb begin
    hue_w = (data_i.in_hue >= 15'(HueFull)) ? '0 : data_i.in_hue;
    if (hue_w < 15'(HueSector)) begin
      s1_d.sector = SecRedYellow;
      base        = '0;
    end else if (hue_w < 15'(2 * HueSector)) begin
      s1_d.sector = SecYellowGreen;
      base        = 15'(HueSector);
    end else if (hue_w < 15'(3 * HueSector)) begin
      s1_d.sector = SecGreenCyan;
      base        = 15'(2 * HueSector);
    end else if (hue_w < 15'(4 * HueSector)) begin
      s1_d.sector = SecCyanBlue;
      base        = 15'(3 * HueSector);
    end else if (hue_w < 15'(5 * HueSector)) begin
      s1_d.sector = SecBlueMagenta;
      base        = 15'(4 * HueSector);
    end else begin
      s1_d.sector = SecMagentaRed;
      base        = 15'(5 * HueSector);
    end
    s1_d.func  = data_i.func;
    s1_d.red   = data_i.in_red;
    s1_d.green = data_i.in_green;
    s1_d.blue  = data_i.in_blue;
    s1_d.hue   = hue_w;
    s1_d.sat   = data_i.in_sat;
    s1_d.val   = data_i.in_val;
    s1_d.frac  = 12'(hue_w - base);
    sat_c      = 8'(ChanMax) - data_i.in_sat;
    s1_d.vs    = 16'(data_i.in_val) * 16'(data_i.in_sat);
    s1_d.pnum  = 16'(data_i.in_val) * 16'(sat_c);

    red_max   = (data_i.in_red >= data_i.in_green) && (data_i.in_red >= data_i.in_blue);
    green_max = !red_max && (data_i.in_green >= data_i.in_blue);
    if (red_max) begin
      s1_d.sel = SelRed;
      s1_d.mx  = data_i.in_red;
      opa      = data_i.in_green;
      opb      = data_i.in_blue;
    end else if (green_max) begin
      s1_d.sel = SelGreen;
      s1_d.mx  = data_i.in_green;
      opa      = data_i.in_blue;
      opb      = data_i.in_red;
    end else begin
      s1_d.sel = SelBlue;
      s1_d.mx  = data_i.in_blue;
      opa      = data_i.in_red;
      opb      = data_i.in_green;
    end
    if (data_i.in_red <= data_i.in_green) begin
      mn = (data_i.in_red <= data_i.in_blue) ? data_i.in_red : data_i.in_blue;
    end else begin
      mn = (data_i.in_green <= data_i.in_blue) ? data_i.in_green : data_i.in_blue;
    end
    s1_d.delta = s1_d.mx - mn;
    s1_d.neg   = opa < opb;
    s1_d.dmag  = s1_d.neg ? (opb - opa) : (opa - opb);
  end

  logic [ProdWidth-1:0] xq, xt, sq, st;
  logic [11:0]          frac_c;
  logic [NumWidth-1:0]  hnum, snum;
  logic [15:0]          pfix;

  // Stage 2: products and numerators, load the divider lanes
  always_comb begin
    frac_c = 12'(HueSector) - s1_q.frac;
    xq     = ProdWidth'(s1_q.vs) * ProdWidth'(s1_q.frac);
    xt     = ProdWidth'(s1_q.vs) * ProdWidth'(frac_c);
    // ceil(x / FullScale) as floor((x + FullScale - 1) / FullScale)
    sq     = xq + ProdWidth'(FullScale - 1);
    st     = xt + ProdWidth'(FullScale - 1);
    hnum   = NumWidth'(s1_q.dmag) * NumWidth'(HueSector);
    snum   = NumWidth'(s1_q.delta) * NumWidth'(ChanMax);
    // floor(x / 255) as (x + x / 256 + 1) / 256, exact over 0..65025
    pfix   = s1_q.pnum + 16'(s1_q.pnum[15:8]) + 16'd1;

    s2_d.side.func   = s1_q.func;
    s2_d.side.red    = s1_q.red;
    s2_d.side.green  = s1_q.green;
    s2_d.side.blue   = s1_q.blue;
    s2_d.side.hue    = s1_q.hue;
    s2_d.side.sat    = s1_q.sat;
    s2_d.side.p      = pfix[15:8];
    s2_d.side.sector = s1_q.sector;
    s2_d.side.sel    = s1_q.sel;
    s2_d.side.neg    = s1_q.neg;
    s2_d.side.black  = (s1_q.mx == '0);
    s2_d.side.grey   = (s1_q.delta == '0);
    if (s1_q.func == FuncRgbToHsv) begin
      s2_d.side.val     = s1_q.mx;
      s2_d.lane[LaneA]  = lane_init(hnum, DivBits'(s1_q.delta));
      s2_d.lane[LaneB]  = lane_init(snum, DivBits'(s1_q.mx));
    end else begin
      s2_d.side.val     = s1_q.val;
      s2_d.lane[LaneA]  = lane_init(sq[ProdWidth-1:CeilShift], DivBits'(CeilDivisor));
      s2_d.lane[LaneB]  = lane_init(st[ProdWidth-1:CeilShift], DivBits'(CeilDivisor));
    end
  end

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_valid_q;
  assign data_o   = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) s1_q <= s1_d;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
  end

endmodule

>>> hdl/hsvrgb_div.sv
// Pipelined restoring divider: all lanes advance a few quotient bits per stage.
module hsvrgb_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsvrgb_pkg::mid_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsvrgb_pkg::mid_t data_o
);
  import hsvrgb_pkg::*;

  logic [DivStages-1:0] vld_q, in_v, stg_ready, nxt_ready;
  mid_t                 mid_q [DivStages];
  mid_t                 in_d  [DivStages];
  mid_t                 stg_d [DivStages];

  assign in_v[0]                 = valid_i;
  assign in_d[0]                 = data_i;
  assign nxt_ready[DivStages-1]  = ready_i;

  for (genvar k = 1; k < DivStages; k++) begin : g_link
    assign in_v[k]        = vld_q[k-1];
    assign in_d[k]        = mid_q[k-1];
    assign nxt_ready[k-1] = stg_ready[k];
  end

  assign stg_ready = ~vld_q | nxt_ready;

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      stg_d[k] = in_d[k];
      for (int l = 0; l < NumLanes; l++) begin
        stg_d[k].lane[l] = div_steps(in_d[k].lane[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < DivStages; k++) begin
        if (stg_ready[k]) vld_q[k] <= in_v[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (stg_ready[k] && in_v[k]) mid_q[k] <= stg_d[k];
    end
  end

  assign ready_o = stg_ready[0];
  assign valid_o = vld_q[DivStages-1];
  assign data_o  = mid_q[DivStages-1];

endmodule

>>> hdl/hsvrgb_post.sv
// Output stage: channel selection, hue assembly and the result register.
module hsvrgb_post (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsvrgb_pkg::mid_t      data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsvrgb_pkg::out_beat_t data_o
);
  import hsvrgb_pkg::*;

  out_beat_t   out_d, out_q;
  logic        vld_q;
  logic [7:0]  v, p, q, t;
  logic [11:0] hq;
  logic [15:0] hsum, hbase;

  always_comb begin
    v = data_i.side.val;
    p = data_i.side.p;
    q = v - data_i.lane[LaneA].quo[7:0];
    t = v - data_i.lane[LaneB].quo[7:0];
    hq = data_i.lane[LaneA].quo;
    case (data_i.side.sel)
      SelRed:   hbase = '0;
      SelGreen: hbase = 16'(2 * HueSector);
      SelBlue:  hbase = 16'(4 * HueSector);
      default:  hbase = '0;
    endcase
    hsum = hbase + (data_i.side.neg ? (16'd0 - 16'(hq)) : 16'(hq));
    // wrap a negative hue back into range
    if (hsum[15]) hsum = hsum + 16'(HueFull);

    out_d.out_val       = v;
    out_d.hue_undefined = 1'b0;
    if (data_i.side.func == FuncRgbToHsv) begin
      out_d.out_red   = data_i.side.red;
      out_d.out_green = data_i.side.green;
      out_d.out_blue  = data_i.side.blue;
      out_d.out_sat   = data_i.lane[LaneB].quo[7:0];
      out_d.out_hue   = hsum[14:0];
      if (data_i.side.black) begin
        out_d.out_sat       = '0;
        out_d.out_hue       = '0;
        out_d.hue_undefined = 1'b1;
      end else if (data_i.side.grey) begin
        out_d.out_hue = '0;
      end
    end else begin
      out_d.out_hue = data_i.side.hue;
      out_d.out_sat = data_i.side.sat;
      case (data_i.side.sector)
        SecRedYellow: begin
          out_d.out_red = v; out_d.out_green = t; out_d.out_blue = p;
        end
        SecYellowGreen: begin
          out_d.out_red = q; out_d.out_green = v; out_d.out_blue = p;
        end
        SecGreenCyan: begin
          out_d.out_red = p; out_d.out_green = v; out_d.out_blue = t;
        end
        SecCyanBlue: begin
          out_d.out_red = p; out_d.out_green = q; out_d.out_blue = v;
        end
        SecBlueMagenta: begin
          out_d.out_red = t; out_d.out_green = p; out_d.out_blue = v;
        end
        SecMagentaRed: begin
          out_d.out_red = v; out_d.out_green = p; out_d.out_blue = q;
        end
        default: begin
          out_d.out_red = v; out_d.out_green = v; out_d.out_blue = v;
        end
      endcase
      // zero saturation: grey
      if (data_i.side.sat == '0) begin
        out_d.out_red   = v;
        out_d.out_green = v;
        out_d.out_blue  = v;
      end
    end
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) out_q <= out_d;
  end

endmodule

>>> hdl/hsvrgb_checker.sv
// Port-level checks of the converter, bound to the top level.
module hsvrgb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input hsvrgb_pkg::out_beat_t out_data_o
);
  import hsvrgb_pkg::*;

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // The input side can only back up behind a full, stalled output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_hue < 15'(HueFull))
    else $error("hue out of range");

  // Undefined hue only for black input, with zeroed hue, saturation and value
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hue_undefined |->
      out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
      out_data_o.out_blue == '0 && out_data_o.out_hue == '0 &&
      out_data_o.out_sat == '0 && out_data_o.out_val == '0)
    else $error("hue_undefined on a non-black result");

endmodule

bind hsv_rgb_color_converter_unit hsvrgb_checker u_checker (.*);
